// File: src/scrf_pkg.sv
// shared types, constants and register codes of the sensor change report framer
package scrf_pkg;

  localparam int ADC_BITS = 10;
  localparam int REF_MV = 1450;
  // dividend 2^ADC_BITS * 1450 needs ADC_BITS + 11 bits
  localparam int DIVD_W = ADC_BITS + 11;
  localparam int DIVIDEND = (1 << ADC_BITS) * REF_MV;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] DEVICE_ID_RST = 32'hDEAD0002;
  localparam logic [15:0] HEARTBEAT_RST = 16'd3296;
  localparam logic [15:0] QUIET_RST = 16'd32767;
  localparam logic [15:0] MV_MAX = 16'hFFFF;

  localparam int BYTE_IDX_W = 4;
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ID = 1'b0,
    CFG_HEARTBEAT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REASON_BOTH      = 2'd0,
    REASON_REED      = 2'd1,
    REASON_TAMPER    = 2'd2,
    REASON_HEARTBEAT = 2'd3
  } reason_t;

  typedef struct packed {
    logic                reed_switch;
    logic                tamper_switch;
    logic [ADC_BITS-1:0] adc_code;
  } in_word_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic [1:0] reason_code;
    logic       last_byte;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic byte_take;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic report;
    logic div_done;
    logic last_byte;
  } status_t;

endpackage

// File: src/scrf_div.sv
// serial restoring divider: constant dividend over the adc code, one quotient bit a cycle
module scrf_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [scrf_pkg::ADC_BITS-1:0]  divisor,
  output logic [scrf_pkg::DIVD_W-1:0]    quotient,
  output logic                           done
);

  logic [scrf_pkg::DIVD_W-1:0]    quo_r;
  logic [scrf_pkg::ADC_BITS-1:0]  rem_r;
  logic [scrf_pkg::ADC_BITS-1:0]  dvs_r;
  logic [scrf_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [scrf_pkg::ADC_BITS:0]    rem_sh;
  logic [scrf_pkg::ADC_BITS:0]    rem_diff;
  logic                           q_bit;
  logic [scrf_pkg::ADC_BITS-1:0]  rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, quo_r[scrf_pkg::DIVD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    q_bit    = (rem_sh >= {1'b0, dvs_r});
    // a zero divisor makes every bit one, the result saturates downstream
    rem_nxt  = q_bit ? rem_diff[scrf_pkg::ADC_BITS-1:0] : rem_sh[scrf_pkg::ADC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= scrf_pkg::DIV_CNT_W'(scrf_pkg::DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - scrf_pkg::DIV_CNT_W'(1);
        if (cnt_r == scrf_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= scrf_pkg::DIVD_W'(scrf_pkg::DIVIDEND);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[scrf_pkg::DIVD_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: src/scrf_dp.sv
// datapath: config registers, switch history, quiet count, divider and byte mux
module scrf_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [scrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scrf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  scrf_pkg::in_word_t               in_word,
  input  scrf_pkg::cmd_t                   cmd,
  output scrf_pkg::status_t                status,
  output scrf_pkg::out_word_t              out_word
);

  logic [31:0]                        device_id_r;
  logic [15:0]                        heartbeat_r;
  logic                               last_reed_r;
  logic                               last_tamper_r;
  logic [15:0]                        quiet_r;
  logic                               reed_r;
  logic                               tamper_r;
  logic                               code_zero_r;
  scrf_pkg::reason_t                  reason_r;
  logic [scrf_pkg::BYTE_IDX_W-1:0]    idx_r;

  logic                               rc;
  logic                               tc;
  logic                               hb;
  logic                               report;
  scrf_pkg::reason_t                  reason_nxt;
  logic                               div_start;
  logic                               div_done;
  logic [scrf_pkg::DIVD_W-1:0]        quotient;
  logic [15:0]                        mv;
  logic [7:0]                         chk;
  logic [7:0]                         byte_sel;

  always_comb begin
    rc = in_word.reed_switch ^ last_reed_r;
    tc = in_word.tamper_switch ^ last_tamper_r;
    hb = (quiet_r >= heartbeat_r);
    report = rc | tc | hb;
    if (rc && tc) begin
      reason_nxt = scrf_pkg::REASON_BOTH;
    end else if (rc) begin
      reason_nxt = scrf_pkg::REASON_REED;
    end else if (tc) begin
      reason_nxt = scrf_pkg::REASON_TAMPER;
    end else begin
      reason_nxt = scrf_pkg::REASON_HEARTBEAT;
    end
  end

  assign div_start = cmd.accept & report;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= scrf_pkg::DEVICE_ID_RST;
      heartbeat_r <= scrf_pkg::HEARTBEAT_RST;
    end else if (cfg_we) begin
      unique case (scrf_pkg::cfg_reg_t'(cfg_index))
        scrf_pkg::CFG_DEVICE_ID: device_id_r <= cfg_wdata;
        scrf_pkg::CFG_HEARTBEAT: heartbeat_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_reed_r   <= 1'b0;
      last_tamper_r <= 1'b0;
      quiet_r       <= scrf_pkg::QUIET_RST;
      idx_r         <= '0;
    end else begin
      if (cmd.accept) begin
        idx_r <= '0;
        if (report) begin
          last_reed_r   <= in_word.reed_switch;
          last_tamper_r <= in_word.tamper_switch;
          quiet_r       <= '0;
        end else if (quiet_r != 16'hFFFF) begin
          quiet_r <= quiet_r + 16'd1;
        end
      end else if (cmd.byte_take) begin
        idx_r <= idx_r + scrf_pkg::BYTE_IDX_W'(1);
      end
    end
  end

  // report payload, held for the nine bytes
  always_ff @(posedge clk) begin
    if (div_start) begin
      reed_r      <= in_word.reed_switch;
      tamper_r    <= in_word.tamper_switch;
      code_zero_r <= (in_word.adc_code == '0);
      reason_r    <= reason_nxt;
    end
  end

  scrf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (in_word.adc_code),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    if (code_zero_r || (|quotient[scrf_pkg::DIVD_W-1:16])) begin
      mv = scrf_pkg::MV_MAX;
    end else begin
      mv = quotient[15:0];
    end
    chk = device_id_r[31:24] ^ device_id_r[23:16] ^ device_id_r[15:8] ^ device_id_r[7:0]
        ^ {7'd0, tamper_r} ^ {7'd0, reed_r} ^ mv[15:8] ^ mv[7:0];
    case (idx_r)
      4'd0:    byte_sel = device_id_r[31:24];
      4'd1:    byte_sel = device_id_r[23:16];
      4'd2:    byte_sel = device_id_r[15:8];
      4'd3:    byte_sel = device_id_r[7:0];
      4'd4:    byte_sel = {7'd0, tamper_r};
      4'd5:    byte_sel = {7'd0, reed_r};
      4'd6:    byte_sel = mv[15:8];
      4'd7:    byte_sel = mv[7:0];
      default: byte_sel = chk;
    endcase
  end

  assign out_word.packet_byte = byte_sel;
  assign out_word.reason_code = reason_r;
  assign out_word.last_byte   = (idx_r == scrf_pkg::LAST_BYTE_IDX);

  assign status.report    = report;
  assign status.div_done  = div_done;
  assign status.last_byte = (idx_r == scrf_pkg::LAST_BYTE_IDX);

endmodule

// File: src/scrf_ctrl.sv
// controller: accept a tick, wait for the divider, hand out the nine report words
module scrf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  scrf_pkg::status_t  status,
  output scrf_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SEND
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  always_comb begin
    cmd.accept    = in_valid & in_ready_r;
    cmd.byte_take = out_valid_r & out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          // a tick that causes no report finishes in its accept cycle
          if (cmd.accept && status.report) begin
            state_r    <= ST_DIVIDE;
            in_ready_r <= 1'b0;
          end
        end
        ST_DIVIDE: begin
          if (status.div_done) begin
            state_r     <= ST_SEND;
            out_valid_r <= 1'b1;
          end
        end
        ST_SEND: begin
          if (cmd.byte_take && status.last_byte) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("input ready while a report word is pending");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> state_r == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_report_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && status.report |=> !in_ready_r && state_r == ST_DIVIDE)
    else $error("report tick did not start the divider");

  a_send_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND && cmd.byte_take && !status.last_byte |=> state_r == ST_SEND)
    else $error("report cut short before the checksum word");

endmodule

// File: src/sensor_change_report_framer_core.sv
// top level of the sensor change report framer
// Takes one tick word (reed level, tamper level, reference adc code) when in_ready is high.
// A tick that changes neither switch and has not reached the heartbeat limit only bumps
// the quiet count and is done in its accept cycle. Otherwise nine report words follow:
// device id msb first, tamper, reed, supply millivolts (2^ADC_BITS*1450/code, saturated
// to 65535, zero code gives 65535) big-endian, and the xor checksum flagged by last_byte.
// The millivolt value is worked out by the bit-serial restoring divider before the first word;
// no new tick is taken until the checksum word has been accepted.
module sensor_change_report_framer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [scrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scrf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  scrf_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output scrf_pkg::out_word_t              out_data
);

  scrf_pkg::cmd_t    cmd;
  scrf_pkg::status_t status;

  scrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  scrf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_word  (out_data)
  );

endmodule

// File: test/sensor_change_report_framer_tb.sv
// testbench for the sensor change report framer: directed and random ticks, report bytes checked in order
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REF_MILLIVOLTS = 1450;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 54;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [scrf_pkg::CFG_IDX_W-1:0] cfg_index = scrf_pkg::CFG_DEVICE_ID;
  logic [scrf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  scrf_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  scrf_pkg::out_word_t out_data;

  // predictor copy of the block's registers and state
  logic [31:0] id_reg = scrf_pkg::DEVICE_ID_RST;
  logic [15:0] hb_limit = scrf_pkg::HEARTBEAT_RST;
  logic seen_reed = 1'b0;
  logic seen_tamper = 1'b0;
  logic [15:0] quiet_ticks = scrf_pkg::QUIET_RST;

  scrf_pkg::in_word_t queued_ticks[$];
  scrf_pkg::out_word_t pending_bytes[$];
  int faults = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;
  logic stim_reed = 1'b0;
  logic stim_tamper = 1'b0;

  sensor_change_report_framer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] supply_millivolts(
    input logic [scrf_pkg::ADC_BITS-1:0] code);
    int unsigned q;
    if (code == '0) return scrf_pkg::MV_MAX;
    q = ((32'd1 << scrf_pkg::ADC_BITS) * REF_MILLIVOLTS) / code;
    return (q > 32'd65535) ? scrf_pkg::MV_MAX : q[15:0];
  endfunction

  // works out the nine report bytes a tick causes, or just bumps the quiet count
  task automatic frame_tick(input scrf_pkg::in_word_t t);
    logic reed_moved;
    logic tamper_moved;
    scrf_pkg::reason_t why;
    logic [15:0] mv;
    logic [7:0] frame [9];
    logic [7:0] chk;
    scrf_pkg::out_word_t w;
    reed_moved = t.reed_switch != seen_reed;
    tamper_moved = t.tamper_switch != seen_tamper;
    if (reed_moved && tamper_moved) why = scrf_pkg::REASON_BOTH;
    else if (reed_moved) why = scrf_pkg::REASON_REED;
    else if (tamper_moved) why = scrf_pkg::REASON_TAMPER;
    else if (quiet_ticks >= hb_limit) why = scrf_pkg::REASON_HEARTBEAT;
    else begin
      if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
      return;
    end
    mv = supply_millivolts(t.adc_code);
    frame[0] = id_reg[31:24];
    frame[1] = id_reg[23:16];
    frame[2] = id_reg[15:8];
    frame[3] = id_reg[7:0];
    frame[4] = {7'd0, t.tamper_switch};
    frame[5] = {7'd0, t.reed_switch};
    frame[6] = mv[15:8];
    frame[7] = mv[7:0];
    chk = 8'd0;
    for (int i = 0; i < 8; i++) chk = chk ^ frame[i];
    frame[8] = chk;
    for (int i = 0; i < 9; i++) begin
      w.packet_byte = frame[i];
      w.reason_code = why;
      w.last_byte = (i == 8);
      pending_bytes.push_back(w);
    end
    seen_reed = t.reed_switch;
    seen_tamper = t.tamper_switch;
    quiet_ticks = 16'd0;
  endtask

  // driver: one word held until taken, then the next from the queue
  always @(posedge clk) begin
    logic busy;
    busy = in_valid;
    if (rst_n && in_valid && in_ready) begin
      frame_tick(in_data);
      busy = 1'b0;
    end
    if (rst_n && !busy && queued_ticks.size() > 0 &&
        !($urandom_range(99) < send_idle_pct)) begin
      in_data <= queued_ticks.pop_front();
      busy = 1'b1;
    end
    in_valid <= busy;
  end

  // monitor: check each accepted word against the oldest pending byte
  always @(posedge clk) begin
    scrf_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected word: byte %02h reason %0d last %0d",
                   out_data.packet_byte, out_data.reason_code, out_data.last_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.packet_byte !== want.packet_byte ||
            out_data.reason_code !== want.reason_code ||
            out_data.last_byte !== want.last_byte) begin
          faults++;
          if (faults <= 10)
            $display({"mismatch: wanted byte %02h reason %0d last %0d, ",
                      "got byte %02h reason %0d last %0d"},
                     want.packet_byte, want.reason_code, want.last_byte,
                     out_data.packet_byte, out_data.reason_code, out_data.last_byte);
        end
      end
    end
    out_ready <= rst_n && !rx_hold && !($urandom_range(99) < recv_idle_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input scrf_pkg::cfg_reg_t idx,
                           input logic [scrf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      scrf_pkg::CFG_DEVICE_ID: id_reg = val;
      scrf_pkg::CFG_HEARTBEAT: hb_limit = val[15:0];
      default: ;
    endcase
  endtask

  task automatic add_tick(input logic reed, input logic tamper, input int code);
    scrf_pkg::in_word_t t;
    t.reed_switch = reed;
    t.tamper_switch = tamper;
    t.adc_code = code[scrf_pkg::ADC_BITS-1:0];
    queued_ticks.push_back(t);
    stim_reed = reed;
    stim_tamper = tamper;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (queued_ticks.size() != 0 || in_valid || pending_bytes.size() != 0);
    // quiet ticks give no word, so leave the block time to finish
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 72 : (mode == IDLE_BOTH) ? 8 : 0;
    recv_idle_pct = (mode == IDLE_RECEIVER) ? 72 : (mode == IDLE_BOTH) ? 8 : 0;
  endtask

  initial begin
    logic [15:0] hb_pick [RANDOM_PHASES];
    int kind;
    int code;
    hb_pick = '{16'd2, 16'd5, 16'd1, 16'd0, 16'd3, 16'd65535, 16'd4, 16'd7};
    hb_pick[6] = 16'($urandom_range(9, 2));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(IDLE_NONE);

    // reset values: first quiet tick is a heartbeat from the preset count
    add_tick(1'b0, 1'b0, 512);
    add_tick(1'b0, 1'b0, 1);
    add_tick(1'b1, 1'b0, 0);
    add_tick(1'b1, 1'b1, 1);
    add_tick(1'b0, 1'b0, 22);
    add_tick(1'b0, 1'b0, 23);
    add_tick(1'b1, 1'b1, 1023);
    drain();

    // zero heartbeat limit reports on every tick
    write_reg(scrf_pkg::CFG_DEVICE_ID, 32'h0000_0000);
    write_reg(scrf_pkg::CFG_HEARTBEAT, 32'd0);
    add_tick(1'b1, 1'b1, 0);
    add_tick(1'b1, 1'b1, 1023);
    add_tick(1'b1, 1'b1, 700);
    drain();

    write_reg(scrf_pkg::CFG_DEVICE_ID, 32'hFFFF_FFFF);
    write_reg(scrf_pkg::CFG_HEARTBEAT, 32'd1);
    repeat (4) add_tick(1'b1, 1'b1, 341);
    add_tick(1'b0, 1'b1, 2);
    add_tick(1'b0, 1'b0, 1022);
    drain();

    // widest limit: quiet ticks stay silent
    write_reg(scrf_pkg::CFG_DEVICE_ID, 32'h1234_5678);
    write_reg(scrf_pkg::CFG_HEARTBEAT, 32'hFFFF_FFFF);
    repeat (4) add_tick(1'b0, 1'b0, 100);
    add_tick(1'b0, 1'b1, 256);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(scrf_pkg::CFG_DEVICE_ID, $urandom);
      write_reg(scrf_pkg::CFG_HEARTBEAT, {16'($urandom_range(65535)), hb_pick[p]});
      @(negedge clk);
      set_idle(idle_mode_t'(p % 4));
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        kind = $urandom_range(9);
        code = ($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(1023);
        case (kind)
          0, 1: add_tick(~stim_reed, stim_tamper, code);
          2, 3: add_tick(stim_reed, ~stim_tamper, code);
          4, 5: add_tick(~stim_reed, ~stim_tamper, code);
          default: add_tick(stim_reed, stim_tamper, code);
        endcase
      end
      drain();
    end

    if (faults == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sensor_change_report_framer_core.f
src/scrf_pkg.sv
src/scrf_div.sv
src/scrf_dp.sv
src/scrf_ctrl.sv
src/sensor_change_report_framer_core.sv
test/sensor_change_report_framer_tb.sv
